// File: sv/rfo_pkg.sv
package rfo_pkg;

  localparam int MAX_SIDE_DEF = 512;

  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int FIX_W    = 20;
  localparam int POS_W    = 9;
  localparam int CFG_W    = 10;
  localparam int STATUS_W = 2;
  // coordinate width for the coverage test: holds x0+w and col*256 with room for a difference
  localparam int COORD_W  = 24;
  localparam int FRAC_W   = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE  = 2'd2;

  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BACKGROUND    = 2'd2;

  localparam logic [CHAR_W-1:0] SHAPE_FILL    = 8'h52;
  localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h72;
  localparam logic [CHAR_W-1:0] BACKGROUND_RESET = 8'h20;

  // 1.0 in Q15.8
  localparam logic signed [COORD_W-1:0] ONE_FIX = 24'sd256;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic covered;
    logic near_edge;
  } cover_t;

endpackage

// File: sv/rfo_cover.sv
module rfo_cover (
  input  rfo_pkg::coord_t px,
  input  rfo_pkg::coord_t py,
  input  rfo_pkg::coord_t x0,
  input  rfo_pkg::coord_t y0,
  input  rfo_pkg::coord_t x1,
  input  rfo_pkg::coord_t y1,
  output rfo_pkg::cover_t cov
);

  rfo_pkg::coord_t dl;
  rfo_pkg::coord_t dr;
  rfo_pkg::coord_t dt;
  rfo_pkg::coord_t db;

  // distances to the left, right, top and bottom edges; all negative-free when inside
  assign dl = px - x0;
  assign dr = x1 - px;
  assign dt = py - y0;
  assign db = y1 - py;

  assign cov.covered = (dl >= 0) && (dr >= 0) && (dt >= 0) && (db >= 0);
  assign cov.near_edge = (dl < rfo_pkg::ONE_FIX) || (dr < rfo_pkg::ONE_FIX) ||
                         (dt < rfo_pkg::ONE_FIX) || (db < rfo_pkg::ONE_FIX);

endmodule

// File: sv/rfo_canvas.sv
module rfo_canvas #(
  parameter int DEPTH = rfo_pkg::MAX_SIDE_DEF * rfo_pkg::MAX_SIDE_DEF,
  parameter int AW    = 18
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [rfo_pkg::CHAR_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [rfo_pkg::CHAR_W-1:0] rdata
);

  logic [rfo_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rectangle_fill_outline_raster_top.sv
// channel | direction | handshake            | payload
// in      | in        | in_valid / in_stall   | cmd, shape_type, rect_*, paint_char, read_*
// out     | out       | out_valid / out_stall | status, pixel_value
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item at a time; a single write port sweeps the canvas one pixel per cycle
// clear: MAX_SIDE*MAX_SIDE cells; draw: check, then canvas_width*canvas_height pixels;
// read: multiply, add, memory read; stops after the multiply when outside the canvas;
// rejected draw: stops after the check; unused command: straight to the result
// a finished beat waits in the output register while the next item is taken
// rst (synchronous) resets state, out_valid and config; canvas holds garbage until a clear
module rectangle_fill_outline_raster_top #(
  parameter int MAX_SIDE = rfo_pkg::MAX_SIDE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rfo_pkg::CMD_W-1:0]          cmd,
  input  logic [rfo_pkg::CHAR_W-1:0]         shape_type,
  input  logic signed [rfo_pkg::FIX_W-1:0]   rect_left,
  input  logic signed [rfo_pkg::FIX_W-1:0]   rect_top,
  input  logic signed [rfo_pkg::FIX_W-1:0]   rect_span_x,
  input  logic signed [rfo_pkg::FIX_W-1:0]   rect_span_y,
  input  logic [rfo_pkg::CHAR_W-1:0]         paint_char,
  input  logic [rfo_pkg::POS_W-1:0]          read_col,
  input  logic [rfo_pkg::POS_W-1:0]          read_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rfo_pkg::STATUS_W-1:0]       status,
  output logic [rfo_pkg::CHAR_W-1:0]         pixel_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [rfo_pkg::CFG_W-1:0]          cfg_data
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW    = CW + 1;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CLEAR   = 4'd1;
  localparam logic [3:0] ST_CHECK   = 4'd2;
  localparam logic [3:0] ST_DRAW    = 4'd3;
  localparam logic [3:0] ST_RD_MUL  = 4'd4;
  localparam logic [3:0] ST_RD_ADDR = 4'd5;
  localparam logic [3:0] ST_RD_WAIT = 4'd6;
  localparam logic [3:0] ST_RD_DATA = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  logic [3:0] state;

  logic [SW-1:0]                 canvas_width;
  logic [SW-1:0]                 canvas_height;
  logic [rfo_pkg::CHAR_W-1:0]    background_char;
  logic [SW-1:0]                 cfg_side;

  logic [rfo_pkg::CHAR_W-1:0]    item_type;
  logic signed [rfo_pkg::FIX_W-1:0] item_left;
  logic signed [rfo_pkg::FIX_W-1:0] item_top;
  logic signed [rfo_pkg::FIX_W-1:0] item_span_x;
  logic signed [rfo_pkg::FIX_W-1:0] item_span_y;
  logic [rfo_pkg::CHAR_W-1:0]    item_char;
  logic [rfo_pkg::POS_W-1:0]     item_col;
  logic [rfo_pkg::POS_W-1:0]     item_row;

  rfo_pkg::coord_t               box_x0;
  rfo_pkg::coord_t               box_y0;
  rfo_pkg::coord_t               box_x1;
  rfo_pkg::coord_t               box_y1;
  rfo_pkg::coord_t               pix_x;
  rfo_pkg::coord_t               pix_y;
  rfo_pkg::cover_t               cov;

  logic [CW-1:0]                 col;
  logic [CW-1:0]                 row;
  logic [AW-1:0]                 addr;
  logic [AW-1:0]                 row_base;
  logic [AW-1:0]                 row_base_next;
  logic [AW-1:0]                 rd_prod;
  logic [AW-1:0]                 rd_addr;
  logic                          col_last;
  logic                          row_last;
  logic                          paint;

  logic                          mem_we;
  logic [rfo_pkg::CHAR_W-1:0]    mem_wdata;
  logic [rfo_pkg::CHAR_W-1:0]    mem_rdata;

  logic [rfo_pkg::STATUS_W-1:0]  res_status;
  logic [rfo_pkg::CHAR_W-1:0]    res_pixel;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // size registers: zero reads as one, oversize as MAX_SIDE
  always_comb begin
    if (cfg_data == '0) begin
      cfg_side = SW'(1);
    end else if (11'(cfg_data) > 11'(MAX_SIDE)) begin
      cfg_side = SW'(MAX_SIDE);
    end else begin
      cfg_side = SW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= SW'(1);
      canvas_height   <= SW'(1);
      background_char <= rfo_pkg::BACKGROUND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfo_pkg::REG_CANVAS_WIDTH:  canvas_width    <= cfg_side;
        rfo_pkg::REG_CANVAS_HEIGHT: canvas_height   <= cfg_side;
        rfo_pkg::REG_BACKGROUND:    background_char <= cfg_data[rfo_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix_x = rfo_pkg::coord_t'({col, rfo_pkg::FRAC_W'(0)});
  assign pix_y = rfo_pkg::coord_t'({row, rfo_pkg::FRAC_W'(0)});

  rfo_cover u_cover (
    .px (pix_x),
    .py (pix_y),
    .x0 (box_x0),
    .y0 (box_y0),
    .x1 (box_x1),
    .y1 (box_y1),
    .cov(cov)
  );

  assign col_last      = ((SW'(col) + SW'(1)) == canvas_width);
  assign row_last      = ((SW'(row) + SW'(1)) == canvas_height);
  assign row_base_next = row_base + AW'(MAX_SIDE);

  always_comb begin
    paint = 1'b0;
    if (cov.covered) begin
      if (item_type == rfo_pkg::SHAPE_FILL) begin
        paint = 1'b1;
      end else if (item_type == rfo_pkg::SHAPE_OUTLINE) begin
        paint = cov.near_edge;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = item_char;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_wdata = background_char;
    end else if (state == ST_DRAW) begin
      mem_we    = paint;
    end
  end

  rfo_canvas #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_canvas (
    .clk  (clk),
    .we   (mem_we),
    .waddr(addr),
    .wdata(mem_wdata),
    .raddr(rd_addr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // done reloads the output register itself when the beat leaves
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item_type   <= shape_type;
            item_left   <= rect_left;
            item_top    <= rect_top;
            item_span_x <= rect_span_x;
            item_span_y <= rect_span_y;
            item_char   <= paint_char;
            item_col    <= read_col;
            item_row    <= read_row;
            res_status  <= rfo_pkg::STATUS_OK;
            res_pixel   <= '0;
            addr        <= '0;
            row_base    <= '0;
            col         <= '0;
            row         <= '0;
            unique case (cmd)
              rfo_pkg::CMD_CLEAR: state <= ST_CLEAR;
              rfo_pkg::CMD_DRAW:  state <= ST_CHECK;
              rfo_pkg::CMD_READ:  state <= ST_RD_MUL;
              default:            state <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: begin
          addr <= addr + AW'(1);
          if (addr == AW'(DEPTH - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_CHECK: begin
          box_x0 <= rfo_pkg::coord_t'(item_left);
          box_y0 <= rfo_pkg::coord_t'(item_top);
          box_x1 <= rfo_pkg::coord_t'(item_left) + rfo_pkg::coord_t'(item_span_x);
          box_y1 <= rfo_pkg::coord_t'(item_top) + rfo_pkg::coord_t'(item_span_y);
          if (item_span_x <= 0 || item_span_y <= 0 ||
              (item_type != rfo_pkg::SHAPE_FILL && item_type != rfo_pkg::SHAPE_OUTLINE)) begin
            res_status <= rfo_pkg::STATUS_REJECTED;
            state      <= ST_DONE;
          end else begin
            state <= ST_DRAW;
          end
        end
        ST_DRAW: begin
          if (col_last) begin
            col      <= '0;
            row      <= row + CW'(1);
            row_base <= row_base_next;
            addr     <= row_base_next;
            if (row_last) begin
              state <= ST_DONE;
            end
          end else begin
            col  <= col + CW'(1);
            addr <= addr + AW'(1);
          end
        end
        ST_RD_MUL: begin
          rd_prod <= AW'(item_row) * AW'(MAX_SIDE);
          if (12'(item_col) >= 12'(canvas_width) || 12'(item_row) >= 12'(canvas_height)) begin
            res_status <= rfo_pkg::STATUS_OUTSIDE;
            state      <= ST_DONE;
          end else begin
            state <= ST_RD_ADDR;
          end
        end
        ST_RD_ADDR: begin
          rd_addr <= rd_prod + AW'(item_col);
          state   <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          state <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          res_pixel <= mem_rdata;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            status      <= res_status;
            pixel_value <= res_pixel;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == ST_IDLE)
    else $error("input taken outside idle");

  a_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_DRAW))
    else $error("canvas written outside a sweep");

  a_row_in_canvas: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAW |-> (SW'(row) < canvas_height && SW'(col) < canvas_width))
    else $error("draw sweep left the canvas");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result beat raised outside done");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
